// ===== hdl/mtep_pkg.sv =====
`default_nettype none

package mtep_pkg;

  // Parser phases
  localparam int unsigned PhaseW = 3;
  localparam logic [PhaseW-1:0] PH_DELTA   = 3'd0;
  localparam logic [PhaseW-1:0] PH_STATUS  = 3'd1;
  localparam logic [PhaseW-1:0] PH_DATA_A  = 3'd2;
  localparam logic [PhaseW-1:0] PH_DATA_B  = 3'd3;
  localparam logic [PhaseW-1:0] PH_LENGTH  = 3'd4;
  localparam logic [PhaseW-1:0] PH_PAYLOAD = 3'd5;

  // Status and meta codes
  localparam logic [7:0] ST_PROG_CHANGE = 8'hC0;
  localparam logic [7:0] ST_PITCH_BEND  = 8'hE0;
  localparam logic [7:0] ST_SYSEX       = 8'hF0;
  localparam logic [7:0] ST_SONG_POS    = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL    = 8'hF3;
  localparam logic [7:0] ST_SYSEX_ESC   = 8'hF7;
  localparam logic [7:0] ST_META        = 8'hFF;
  localparam logic [7:0] META_EOT       = 8'h2F;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_EOT     = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] delta_time;
    logic [7:0]  status_byte;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
    logic        payload_last;
  } result_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [7:0]        running_status;
    logic [7:0]        event_status;
    logic [7:0]        data_first;
    logic [7:0]        data_second;
    logic [31:0]       delta_accum;
    logic [31:0]       length_accum;
    logic [31:0]       payload_remaining;
    logic              ended;
  } parse_state_t;

  // Input stage to parser
  typedef struct packed {
    logic       valid;
    logic [7:0] byte_val;
    logic       start;
  } in_item_t;

endpackage

`default_nettype wire

// ===== hdl/mtep_in_stage.sv =====
`default_nettype none

module mtep_in_stage
  import mtep_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire logic [7:0] byte_in_i,
  input  wire logic     track_start_i,
  input  wire logic     advance_i,
  output in_item_t      item_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       start_q;
  logic       load;

  // Hold the item while the parser cannot advance
  assign in_stall_o = valid_q && !advance_i;
  assign load       = !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  // Capture the payload on accept
  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      byte_q  <= byte_in_i;
      start_q <= track_start_i;
    end
  end

  assign item_o.valid    = valid_q;
  assign item_o.byte_val = byte_q;
  assign item_o.start    = start_q;

endmodule

`default_nettype wire

// ===== hdl/mtep_core.sv =====
`default_nettype none

module mtep_core
  import mtep_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire in_item_t item_i,
  input  wire logic     advance_i,
  output logic          res_valid_o,
  output result_t       res_o
);

  parse_state_t state_q;
  parse_state_t state_d;
  parse_state_t cur;
  parse_state_t nxt;
  logic         step;
  logic [7:0]   b;
  logic         do_first;
  logic         do_second;
  logic         do_emit;
  logic [31:0]  emit_len;
  logic [7:0]   s;
  logic         found;
  result_t      res;

  assign step = item_i.valid && advance_i;
  assign b    = item_i.byte_val;

  // Apply a track restart before the byte
  always_comb begin
    cur = state_q;
    if (item_i.start) begin
      cur = '0;
      cur.phase = PH_DELTA;
    end
  end

  // Parse one byte
  always_comb begin
    nxt       = cur;
    found     = 1'b0;
    res       = '0;
    res.kind  = KIND_HEADER;
    do_first  = 1'b0;
    do_second = 1'b0;
    do_emit   = 1'b0;
    emit_len  = '0;
    s         = '0;

    if (!cur.ended) begin
      unique case (cur.phase)
        PH_STATUS: begin
          nxt.data_first  = '0;
          nxt.data_second = '0;
          if (b[7]) begin
            nxt.event_status = b;
            if (b < ST_SYSEX) begin
              nxt.running_status = b;
            end
            if (b < ST_SYSEX || b == ST_SONG_POS || b == ST_SONG_SEL || b == ST_META) begin
              nxt.phase = PH_DATA_A;
            end else begin
              do_first = 1'b1;
            end
          end else begin
            nxt.event_status = cur.running_status;
            nxt.data_first   = b;
            do_first         = 1'b1;
          end
        end
        PH_DATA_A: begin
          nxt.data_first = b;
          do_first       = 1'b1;
        end
        PH_DATA_B: begin
          nxt.data_second = b;
          do_second       = 1'b1;
        end
        PH_LENGTH: begin
          nxt.length_accum = {cur.length_accum[24:0], b[6:0]};
          if (!b[7]) begin
            do_emit  = 1'b1;
            emit_len = nxt.length_accum;
          end
        end
        PH_PAYLOAD: begin
          nxt.payload_remaining = cur.payload_remaining - 32'd1;
          found                 = 1'b1;
          res.kind              = KIND_PAYLOAD;
          res.payload_byte      = b;
          res.payload_last      = (nxt.payload_remaining == '0);
          if (res.payload_last) begin
            nxt.phase       = PH_DELTA;
            nxt.delta_accum = '0;
          end
        end
        default: begin
          nxt.delta_accum = {cur.delta_accum[24:0], b[6:0]};
          nxt.phase       = b[7] ? PH_DELTA : PH_STATUS;
        end
      endcase
    end

    // After the first data byte: end of track, second byte, or on
    s = nxt.event_status;
    if (do_first) begin
      if (s == ST_META && nxt.data_first == META_EOT) begin
        found           = 1'b1;
        res.kind        = KIND_EOT;
        res.delta_time  = cur.delta_accum;
        res.status_byte = ST_META;
        res.first_data  = META_EOT;
        nxt.ended       = 1'b1;
      end else if (s < ST_PROG_CHANGE || (s >= ST_PITCH_BEND && s < ST_SYSEX) ||
                   s == ST_SONG_POS) begin
        nxt.phase = PH_DATA_B;
      end else begin
        do_second = 1'b1;
      end
    end

    // After the second data byte: length or header
    if (do_second) begin
      if (s == ST_SYSEX || s == ST_SYSEX_ESC || s == ST_META) begin
        nxt.length_accum = '0;
        nxt.phase        = PH_LENGTH;
      end else begin
        do_emit = 1'b1;
      end
    end

    // Emit the event header
    if (do_emit) begin
      found              = 1'b1;
      res.kind           = KIND_HEADER;
      res.delta_time     = cur.delta_accum;
      res.status_byte    = nxt.event_status;
      res.first_data     = nxt.data_first;
      res.second_data    = nxt.data_second;
      res.payload_length = emit_len;
      if (emit_len == '0) begin
        nxt.phase       = PH_DELTA;
        nxt.delta_accum = '0;
      end else begin
        nxt.payload_remaining = emit_len;
        nxt.phase             = PH_PAYLOAD;
      end
    end
  end

  assign state_d     = step ? nxt : state_q;
  assign res_valid_o = step && found;
  assign res_o       = res;

  // Clear to the delta time phase, which is code zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_eot_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == KIND_EOT |=> state_q.ended)
    else $error("end of track did not stop the parser");

  a_ended_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && state_q.ended && !item_i.start |-> !res_valid_o)
    else $error("result after end of track");

  a_last_is_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.payload_last |-> res_o.kind == KIND_PAYLOAD)
    else $error("last mark on a non-payload item");

  a_payload_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == PH_PAYLOAD |-> state_q.payload_remaining != '0)
    else $error("payload phase with nothing remaining");
`endif

endmodule

`default_nettype wire

// ===== hdl/midi_track_event_parser.sv =====
`default_nettype none

// Channel  Direction  Handshake             Fields
// in       input      in_valid_i/in_stall_o  byte_in_i, track_start_i
// out      output     out_valid_o/out_stall_i kind_o, delta_time_o, status_byte_o,
//                                            first_data_o, second_data_o,
//                                            payload_length_o, payload_byte_o,
//                                            payload_last_o
//
// One byte per cycle sustained while out_stall_i is low; an accepted byte lands in
// the input register and its result is then captured in the result register.
// Bytes that produce no result simply update the parser state.
// rst_ni clears the parser state and both stage valid flags asynchronously.
// out_stall_i holds the result register; the input register then fills and
// in_stall_o rises, so no item is lost or repeated.

module midi_track_event_parser
  import mtep_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  byte_in_i,
  input  wire logic        track_start_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [31:0]      delta_time_o,
  output logic [7:0]       status_byte_o,
  output logic [7:0]       first_data_o,
  output logic [7:0]       second_data_o,
  output logic [31:0]      payload_length_o,
  output logic [7:0]       payload_byte_o,
  output logic             payload_last_o
);

  in_item_t item;
  logic     advance;
  logic     res_valid;
  result_t  res;
  logic     out_valid_q;
  result_t  out_q;

  // Advance when the result register is free or being taken
  assign advance = !out_valid_q || !out_stall_i;

  mtep_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .byte_in_i     (byte_in_i),
    .track_start_i (track_start_i),
    .advance_i     (advance),
    .item_o        (item)
  );

  mtep_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .advance_i   (advance),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = out_q.kind;
  assign delta_time_o     = out_q.delta_time;
  assign status_byte_o    = out_q.status_byte;
  assign first_data_o     = out_q.first_data;
  assign second_data_o    = out_q.second_data;
  assign payload_length_o = out_q.payload_length;
  assign payload_byte_o   = out_q.payload_byte;
  assign payload_last_o   = out_q.payload_last;

endmodule

`default_nettype wire
